FILE: rtl/core/msppm_pkg.sv
// shared types, constants and helper functions for the mode s sentence encoder
`timescale 1ns / 1ps

package msppm_pkg;

    localparam int MAX_BYTES_DEF = 14;

    localparam logic [15:0] PREAMBLE_CHIPS = 16'hA140;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_LONG  = 3'd1,
        ERR_FRAME = 3'd2,
        ERR_HEX   = 3'd3,
        ERR_ODD   = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TAIL   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OSEL_ERR  = 2'd0,
        OSEL_PRE  = 2'd1,
        OSEL_BYTE = 2'd2
    } t_osel;

    typedef struct packed {
        logic  parse_en;
        logic  load_out;
        t_osel osel;
        logic  clear;
        logic  k_inc;
    } t_cmd;

    typedef struct packed {
        logic err_nz;
        logic empty;
        logic last_byte;
        logic out_free;
    } t_sts;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        case (c) inside
            [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h37)};
            default:       res = 5'd0;
        endcase
        return res;
    endfunction

    // msb first, one -> 10, zero -> 01
    function automatic logic [15:0] byte_chips(input logic [7:0] b);
        logic [15:0] w;
        w = 16'd0;
        for (int i = 0; i < 8; i++) begin
            w[2*i +: 2] = b[i] ? 2'b10 : 2'b01;
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/msppm_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module msppm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 14,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/msppm_dp.sv
// datapath: sentence parser registers, payload ram, chip word output register
`timescale 1ns / 1ps

module msppm_dp #(
    parameter int MAX_BYTES = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_char_code,
    input  msppm_pkg::t_cmd   i_cmd,
    output msppm_pkg::t_sts   o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [15:0]       o_chips,
    output logic              o_last_word,
    output logic [2:0]        o_error_code
);

    import msppm_pkg::*;

    localparam int CNT_W = $clog2(2 * MAX_BYTES + 1);
    localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(2 * MAX_BYTES);

    t_phase           r_phase, n_phase;
    t_err             r_pending, n_pending;
    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0]       r_high, n_high;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_valid, n_valid;
    logic [15:0]      r_chips, n_chips;
    logic             r_last, n_last;
    t_err             r_err, n_err;

    logic             do_digit;
    logic             tail_bad;
    t_err             dig_err;
    t_err             final_err;
    logic [4:0]       hexv;
    logic             wr_en;
    logic [7:0]       rd_data;
    logic [CNT_W-1:0] nbytes;
    logic             last_byte;
    logic             out_free;

    assign hexv      = hex_value(i_char_code);
    assign nbytes    = r_count >> 1;
    assign last_byte = (CNT_W'(r_k) + CNT_W'(1)) == nbytes;
    assign out_free  = !r_valid || !i_out_stall;

    always_comb begin
        if (r_phase != PH_TAIL) begin
            final_err = ERR_FRAME;
        end else if (r_pending != ERR_NONE) begin
            final_err = r_pending;
        end else if (r_count[0]) begin
            final_err = ERR_ODD;
        end else begin
            final_err = ERR_NONE;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_count   = r_count;
        n_high    = r_high;
        n_k       = r_k;
        do_digit  = 1'b0;
        tail_bad  = 1'b0;
        dig_err   = ERR_NONE;
        wr_en     = 1'b0;
        if (i_cmd.parse_en) begin
            case (r_phase)
                PH_START: begin
                    n_phase = PH_DIGITS;
                    if (i_char_code != CH_STAR) begin
                        n_pending = ERR_FRAME;
                    end
                end
                PH_TAIL: begin
                    if (i_char_code != CH_CR && i_char_code != CH_LF) begin
                        tail_bad = 1'b1;
                        do_digit = 1'b1;
                    end
                end
                default: do_digit = 1'b1;
            endcase
            if (do_digit) begin
                if (i_char_code == CH_SEMI) begin
                    n_phase = PH_TAIL;
                end else begin
                    n_phase = PH_DIGITS;
                    if (!hexv[4]) begin
                        dig_err = ERR_HEX;
                    end else if (r_count >= FULL_CNT) begin
                        dig_err = ERR_LONG;
                    end else begin
                        if (!r_count[0]) begin
                            n_high = hexv[3:0];
                        end else begin
                            wr_en = 1'b1;
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                end
                if (r_pending == ERR_NONE) begin
                    n_pending = tail_bad ? ERR_HEX : dig_err;
                end
            end
        end
        if (i_cmd.k_inc) begin
            n_k = r_k + IDX_W'(1);
        end
        if (i_cmd.clear) begin
            n_phase   = PH_START;
            n_pending = ERR_NONE;
            n_count   = '0;
            n_high    = '0;
            n_k       = '0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_chips = r_chips;
        n_last  = r_last;
        n_err   = r_err;
        if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
        if (i_cmd.load_out) begin
            n_valid = 1'b1;
            case (i_cmd.osel)
                OSEL_PRE: begin
                    n_chips = PREAMBLE_CHIPS;
                    n_last  = (nbytes == '0);
                    n_err   = ERR_NONE;
                end
                OSEL_BYTE: begin
                    n_chips = byte_chips(rd_data);
                    n_last  = last_byte;
                    n_err   = ERR_NONE;
                end
                default: begin
                    n_chips = '0;
                    n_last  = 1'b1;
                    n_err   = final_err;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_pending <= ERR_NONE;
            r_count   <= '0;
            r_high    <= '0;
            r_k       <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_high    <= n_high;
            r_k       <= n_k;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chips <= n_chips;
        r_last  <= n_last;
        r_err   <= n_err;
    end

    msppm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W:1]),
        .i_wr_data ({r_high, hexv[3:0]}),
        .i_rd_addr (r_k),
        .o_rd_data (rd_data)
    );

    assign o_sts.err_nz    = (final_err != ERR_NONE);
    assign o_sts.empty     = (nbytes == '0);
    assign o_sts.last_byte = last_byte;
    assign o_sts.out_free  = out_free;

    assign o_out_valid  = r_valid;
    assign o_chips      = r_chips;
    assign o_last_word  = r_last;
    assign o_error_code = r_err;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> out_free)
        else $error("output word loaded while the output register is held");

    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && i_cmd.osel == OSEL_BYTE) |-> (CNT_W'(r_k) < nbytes))
        else $error("byte word index beyond stored payload");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_phase == PH_START && r_count == '0 && r_k == '0))
        else $error("parser not cleared after sentence");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("digit count beyond payload capacity");

endmodule

FILE: rtl/core/msppm_ctrl.sv
// controller: parse, decide and emit sequencing
`timescale 1ns / 1ps

module msppm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_end_of_sentence,
    output logic            o_in_stall,
    input  msppm_pkg::t_sts i_sts,
    output msppm_pkg::t_cmd o_cmd
);

    import msppm_pkg::*;

    typedef enum logic [3:0] {
        S_PARSE  = 4'b0001,
        S_DECIDE = 4'b0010,
        S_BYTE   = 4'b0100,
        S_FETCH  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_PARSE);
    assign accept     = i_in_valid && (r_state == S_PARSE);

    always_comb begin
        n_state        = r_state;
        o_cmd.parse_en = accept;
        o_cmd.load_out = 1'b0;
        o_cmd.osel     = OSEL_ERR;
        o_cmd.clear    = 1'b0;
        o_cmd.k_inc    = 1'b0;
        case (r_state)
            S_PARSE: begin
                if (accept && i_end_of_sentence) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.osel     = i_sts.err_nz ? OSEL_ERR : OSEL_PRE;
                    if (i_sts.err_nz || i_sts.empty) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_PARSE;
                    end else begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_BYTE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.osel     = OSEL_BYTE;
                    if (i_sts.last_byte) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_PARSE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_BYTE;
            default: n_state = S_PARSE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    a_final_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_sentence) |=> (r_state == S_DECIDE))
        else $error("final character did not start the emit sequence");

    a_fetch_then_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_BYTE))
        else $error("fetch not followed by byte word");

    a_clear_to_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> (o_cmd.load_out && n_state == S_PARSE))
        else $error("clear without the final word");

endmodule

FILE: rtl/core/mode_s_hex_sentence_ppm_encoder.sv
// top level: mode s hex sentence to ppm chip word encoder
//
//   channel  direction  beat                                      handshake
//   in       sink       i_char_code, i_end_of_sentence            i_in_valid / o_in_stall
//   out      source     o_chips, o_last_word, o_error_code        o_out_valid / i_out_stall
//
// one character beat per cycle while parsing
// after the final character the controller decides, then loads the first word (error or preamble)
// payload words follow the preamble; after each payload word a fetch state waits for the
// registered payload ram read before the next one is loaded
// input is stalled from the final character until the last word is loaded
// i_rst_n is synchronous; control state clears, payload ram is not cleared
`timescale 1ns / 1ps

module mode_s_hex_sentence_ppm_encoder #(
    parameter int MAX_BYTES = msppm_pkg::MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_sentence,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_chips,
    output logic        o_last_word,
    output logic [2:0]  o_error_code
);

    import msppm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    msppm_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_end_of_sentence (i_end_of_sentence),
        .o_in_stall        (o_in_stall),
        .i_sts             (sts),
        .o_cmd             (cmd)
    );

    msppm_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_code  (i_char_code),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_chips      (o_chips),
        .o_last_word  (o_last_word),
        .o_error_code (o_error_code)
    );

endmodule
